/* rtl/core/day_number_to_week_date_top_defines.svh */
// Assertion macros for the day number to week date block.
// Used by the top level; expects clk and arst_n in scope.
`ifndef DAY_NUMBER_TO_WEEK_DATE_TOP_DEFINES_SVH
`define DAY_NUMBER_TO_WEEK_DATE_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define DNWD_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off during reset
`define DNWD_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/dnwd_pkg.sv */
// Package for the day number to week date block: widths, calendar constants,
// reciprocal constants for division by constants, and shared types. No dependencies.
package dnwd_pkg;

	localparam int DN_W    = 23;
	localparam int Z_W     = 22;
	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int WEEK_W  = 6;
	localparam int YW_W    = 20;
	localparam int YD_W    = 9;
	localparam int ERA_W   = 5;
	localparam int DOE_W   = 18;
	localparam int YOE_W   = 9;

	localparam int LANES     = 2;
	localparam int LANE_DATE = 0;
	localparam int LANE_THU  = 1;

	localparam int DAY_MIN     = -719162;
	localparam int DAY_MAX     = 2932896;
	localparam int EPOCH_SHIFT = 719468;

	localparam int ERA_DAYS  = 146097;
	localparam int DAYS_4Y   = 1460;
	localparam int DAYS_100Y = 36524;
	localparam int YR_DAYS   = 365;

	// floor(x / d) == (x * M) >> K, exact for every x of the stated width
	localparam int D7_K = 25;
	localparam longint unsigned D7_M = ((64'd1 << D7_K) + 64'd6) / 64'd7;
	localparam int D7_MW = $clog2(D7_M + 64'd1);

	localparam int ERA_K = 40;
	localparam longint unsigned ERA_M = ((64'd1 << ERA_K) + 64'd146096) / 64'd146097;
	localparam int ERA_MW = $clog2(ERA_M + 64'd1);

	localparam int D4Y_K = 29;
	localparam longint unsigned D4Y_M = ((64'd1 << D4Y_K) + 64'd1459) / 64'd1460;
	localparam int D4Y_MW = $clog2(D4Y_M + 64'd1);

	localparam int D365_K = 27;
	localparam longint unsigned D365_M = ((64'd1 << D365_K) + 64'd364) / 64'd365;
	localparam int D365_MW = $clog2(D365_M + 64'd1);

	localparam int D153_K = 19;
	localparam longint unsigned D153_M = ((64'd1 << D153_K) + 64'd152) / 64'd153;
	localparam int D153_MW = $clog2(D153_M + 64'd1);

	localparam int WK7_K = 12;
	localparam longint unsigned WK7_M = ((64'd1 << WK7_K) + 64'd6) / 64'd7;
	localparam int WK7_MW = $clog2(WK7_M + 64'd1);

	typedef struct packed {
		logic signed [DN_W-1:0] day_number;
		logic                   is_missing;
	} day_t;

	typedef struct packed {
		logic                  result_missing;
		logic [YEAR_W-1:0]     calendar_year;
		logic [MONTH_W-1:0]    calendar_month;
		logic [DAY_W-1:0]      calendar_day;
		logic                  leap_flag;
		logic [WEEK_W-1:0]     iso_week;
		logic [YEAR_W-1:0]     iso_year;
		logic [YW_W-1:0]       iso_year_week;
		logic [WEEK_W-1:0]     us_week;
		logic [YW_W-1:0]       us_year_week;
	} date_t;

	typedef struct packed {
		logic vld;
		logic ok;
	} ctl_t;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic               leap;
		logic [YD_W-1:0]    yday;
	} civ_t;

endpackage

/* rtl/core/dnwd_stream_if.sv */
// Valid/ready stream interface with a typed payload.
// No dependencies; payload type is set where the interface is instantiated.
interface dnwd_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/day_number_to_week_date_top.sv */
// Day number to calendar and ISO/US week date, fully pipelined.
// Registers: 3 front stages, 9 civil split stages, 1 week stage and 1 output
// register. Throughput: one transaction per cycle while the consumer does not stall;
// the civil split's multiply-by-reciprocal stages set the depth, not the rate.
// Reset (arst_n low, async) clears all valid bits; the block keeps no other state.
`include "day_number_to_week_date_top_defines.svh"

module day_number_to_week_date_top
	import dnwd_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	dnwd_stream_if.sink   day_ch,
	dnwd_stream_if.source date_ch
);
	// Global advance: the whole pipeline moves whenever the output buffer's
	// spare entry is empty. The spare absorbs the one transaction that is in
	// flight when the consumer stalls, so ready never depends on date_ch.ready
	// in the same cycle.
	logic           en;
	ctl_t           f_ctl;
	ctl_t           c_ctl;
	logic [Z_W-1:0] f_z [LANES];
	civ_t           c_civ [LANES];
	logic           w_vld;
	date_t          w_date;

	// range check, z = day count from 0000-03-01, weekday, Thursday of the week
	dnwd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (day_ch.valid),
		.day    (day_ch.data),
		.ctl    (f_ctl),
		.z      (f_z)
	);

	// two lanes: the date itself and its Thursday (gives ISO year and week)
	dnwd_civil u_civil (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctl_in  (f_ctl),
		.z_in    (f_z),
		.ctl_out (c_ctl),
		.civ     (c_civ)
	);

	// week numbers and year*100+week codes; missing inputs give zero fields with the missing flag set
	dnwd_week u_week (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.ctl_in (c_ctl),
		.civ_in (c_civ),
		.vld    (w_vld),
		.date   (w_date)
	);

	dnwd_skid u_skid (
		.clk         (clk),
		.arst_n      (arst_n),
		.fill_valid  (w_vld),
		.fill_data   (w_date),
		.fill_ready  (en),
		.drain_valid (date_ch.valid),
		.drain_ready (date_ch.ready),
		.drain_data  (date_ch.data)
	);

	assign day_ch.ready = en;

	// a missing result carries nothing but the flag
	`DNWD_ASSERT_NOW(a_missing_zero, date_ch.valid && date_ch.data.result_missing, date_ch.data.calendar_year == 14'd0 && date_ch.data.iso_week == 6'd0 && date_ch.data.us_year_week == 20'd0, "missing result with nonzero fields")

	// a good result has a real month, day and ISO week
	`DNWD_ASSERT_NOW(a_fields_range, date_ch.valid && !date_ch.data.result_missing, date_ch.data.calendar_month >= 4'd1 && date_ch.data.calendar_month <= 4'd12 && date_ch.data.calendar_day >= 5'd1 && date_ch.data.iso_week >= 6'd1 && date_ch.data.iso_week <= 6'd53, "date field out of range")

	// ISO year is the civil year or one of its neighbors
	`DNWD_ASSERT_NOW(a_iso_year_near, date_ch.valid && !date_ch.data.result_missing, date_ch.data.iso_year == date_ch.data.calendar_year || date_ch.data.iso_year + 14'd1 == date_ch.data.calendar_year || date_ch.data.iso_year == date_ch.data.calendar_year + 14'd1, "ISO year too far from civil year")

	// input side is blocked only with a result waiting; it stays blocked until taken
	`DNWD_ASSERT_NOW(a_block_has_result, !day_ch.ready, date_ch.valid, "input blocked with no result held")
	`DNWD_ASSERT_NEXT(a_block_holds, !day_ch.ready && !date_ch.ready, !day_ch.ready, "spare entry freed without a transaction")

endmodule

/* rtl/core/dnwd_front.sv */
// Front stages: range check, epoch shift, weekday, Thursday of the same week.
// Depends on dnwd_pkg.
module dnwd_front
	import dnwd_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_vld,
	input  day_t           day,
	output ctl_t           ctl,
	output logic [Z_W-1:0] z [LANES]
);
	localparam int PW   = Z_W + D7_MW;
	localparam int Q7_W = Z_W - 2;

	logic signed [DN_W:0] dn_x;
	logic signed [DN_W:0] z_x;
	logic                 in_rng;
	logic [Z_W-1:0]       w1;
	logic [PW-1:0]        q7_prod;
	logic [Z_W-1:0]       w2;
	logic [Z_W-1:0]       r7;
	logic [2:0]           wd;
	logic [2:0]           mon;

	logic             vld_s1, vld_s2, vld_s3;
	logic             ok_s1, ok_s2, ok_s3;
	logic [Z_W-1:0]   z_s1, z_s2, z_s3;
	logic [Q7_W-1:0]  q7_s2;
	logic [Z_W-1:0]   zt_s3;

	assign dn_x   = (DN_W+1)'(day.day_number);
	assign in_rng = (dn_x >= (DN_W+1)'(DAY_MIN)) && (dn_x <= (DN_W+1)'(DAY_MAX));
	assign z_x    = dn_x + (DN_W+1)'(EPOCH_SHIFT);

	assign w1      = z_s1 + Z_W'(3);
	assign q7_prod = PW'(w1) * PW'(D7_M);

	// remainder of (z + 3) mod 7: 0 is Sunday
	assign w2  = z_s2 + Z_W'(3);
	assign r7  = w2 - Z_W'({q7_s2, 3'b000}) + Z_W'(q7_s2);
	assign wd  = r7[2:0];
	assign mon = (wd == 3'd0) ? 3'd6 : wd - 3'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s1 <= !day.is_missing && in_rng;
			z_s1  <= z_x[Z_W-1:0];
			ok_s2 <= ok_s1;
			z_s2  <= z_s1;
			q7_s2 <= q7_prod[D7_K +: Q7_W];
			ok_s3 <= ok_s2;
			z_s3  <= z_s2;
			zt_s3 <= w2 - Z_W'(mon);
		end
	end

	assign ctl.vld        = vld_s3;
	assign ctl.ok         = ok_s3;
	assign z[LANE_DATE]   = z_s3;
	assign z[LANE_THU]    = zt_s3;

endmodule

/* rtl/core/dnwd_civil.sv */
// Civil date split: day count from 0000-03-01 to year, month, day, leap, day of year.
// Two lanes share the stage control; depends on dnwd_pkg.
module dnwd_civil
	import dnwd_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  ctl_t           ctl_in,
	input  logic [Z_W-1:0] z_in [LANES],
	output ctl_t           ctl_out,
	output civ_t           civ [LANES]
);
	localparam int NST = 9;

	logic [NST-1:0] vld_s;
	logic [NST-1:0] ok_s;

	// days before the month in the March-based year
	function automatic logic [YD_W-1:0] month_off(input logic [3:0] mp);
		logic [YD_W-1:0] r;
		case (mp)
			4'd0:    r = YD_W'(0);
			4'd1:    r = YD_W'(31);
			4'd2:    r = YD_W'(61);
			4'd3:    r = YD_W'(92);
			4'd4:    r = YD_W'(122);
			4'd5:    r = YD_W'(153);
			4'd6:    r = YD_W'(184);
			4'd7:    r = YD_W'(214);
			4'd8:    r = YD_W'(245);
			4'd9:    r = YD_W'(275);
			4'd10:   r = YD_W'(306);
			4'd11:   r = YD_W'(337);
			default: r = YD_W'(0);
		endcase
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NST-2:0], ctl_in.vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s <= {ok_s[NST-2:0], ctl_in.ok};
		end
	end

	assign ctl_out.vld = vld_s[NST-1];
	assign ctl_out.ok  = ok_s[NST-1];

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		localparam int EPW = Z_W + ERA_MW;
		localparam int APW = DOE_W + D4Y_MW;
		localparam int YPW = DOE_W + D365_MW;
		localparam int MPW = 11 + D153_MW;

		logic [EPW-1:0]     era_prod;
		logic [APW-1:0]     a_prod;
		logic [2:0]         cnt_b;
		logic [YPW-1:0]     yoe_prod;
		logic [1:0]         cent;
		logic [DOE_W-1:0]   yr_sub;
		logic [10:0]        mp_x;
		logic [MPW-1:0]     mp_prod;
		logic [YD_W-1:0]    dd;
		logic               jf;
		logic               cent_yr;
		logic               quad_yr;
		logic               leap;

		logic [Z_W-1:0]     z_s1;
		logic [ERA_W-1:0]   era_s1, era_s2, era_s3, era_s4, era_s5, era_s6, era_s7, era_s8;
		logic [DOE_W-1:0]   doe_s2, doe_s3, doe_s4, doe_s5;
		logic [6:0]         a_s3;
		logic [DOE_W-1:0]   n_s4;
		logic [YOE_W-1:0]   yoe_s5, yoe_s6, yoe_s7;
		logic [YD_W-1:0]    doy_s6, doy_s7, doy_s8;
		logic [3:0]         mp_s7;
		logic [DAY_W-1:0]   day_s8;
		logic [MONTH_W-1:0] mon_s8;
		logic               jf_s8;
		logic [YOE_W-1:0]   yp_s8;
		civ_t               civ_s9;

		assign era_prod = EPW'(z_in[l]) * EPW'(ERA_M);
		assign a_prod   = APW'(doe_s2) * APW'(D4Y_M);
		assign cnt_b    = {2'b00, doe_s3 >= DOE_W'(DAYS_100Y)}
		                + {2'b00, doe_s3 >= DOE_W'(2 * DAYS_100Y)}
		                + {2'b00, doe_s3 >= DOE_W'(3 * DAYS_100Y)}
		                + {2'b00, doe_s3 >= DOE_W'(ERA_DAYS - 1)};
		assign yoe_prod = YPW'(n_s4) * YPW'(D365_M);
		assign cent     = {1'b0, yoe_s5 >= YOE_W'(100)}
		                + {1'b0, yoe_s5 >= YOE_W'(200)}
		                + {1'b0, yoe_s5 >= YOE_W'(300)};
		assign yr_sub   = DOE_W'(yoe_s5) * DOE_W'(YR_DAYS)
		                + DOE_W'(yoe_s5 >> 2) - DOE_W'(cent);
		assign mp_x     = {doy_s6, 2'b00} + {2'b00, doy_s6} + 11'd2;
		assign mp_prod  = MPW'(mp_x) * MPW'(D153_M);
		assign dd       = doy_s7 - month_off(mp_s7) + YD_W'(1);
		assign jf       = (mp_s7 >= 4'd10);

		// leap test on the year within the era; an era is a multiple of 400 years
		assign cent_yr = (yp_s8 == YOE_W'(0)) || (yp_s8 == YOE_W'(100))
		              || (yp_s8 == YOE_W'(200)) || (yp_s8 == YOE_W'(300))
		              || (yp_s8 == YOE_W'(400));
		assign quad_yr = (yp_s8 == YOE_W'(0)) || (yp_s8 == YOE_W'(400));
		assign leap    = ((yp_s8[1:0] == 2'b00) && !cent_yr) || quad_yr;

		always_ff @(posedge clk) begin
			if (en) begin
				z_s1   <= z_in[l];
				era_s1 <= era_prod[ERA_K +: ERA_W];
				doe_s2 <= DOE_W'(z_s1 - Z_W'(era_s1) * Z_W'(ERA_DAYS));
				era_s2 <= era_s1;
				doe_s3 <= doe_s2;
				a_s3   <= a_prod[D4Y_K +: 7];
				era_s3 <= era_s2;
				n_s4   <= doe_s3 - DOE_W'(a_s3) + DOE_W'(cnt_b) - DOE_W'(doe_s3 >= DOE_W'(ERA_DAYS - 1));
				doe_s4 <= doe_s3;
				era_s4 <= era_s3;
				yoe_s5 <= yoe_prod[D365_K +: YOE_W];
				doe_s5 <= doe_s4;
				era_s5 <= era_s4;
				doy_s6 <= YD_W'(doe_s5 - yr_sub);
				yoe_s6 <= yoe_s5;
				era_s6 <= era_s5;
				mp_s7  <= mp_prod[D153_K +: 4];
				doy_s7 <= doy_s6;
				yoe_s7 <= yoe_s6;
				era_s7 <= era_s6;
				day_s8 <= dd[DAY_W-1:0];
				mon_s8 <= jf ? mp_s7 - 4'd9 : mp_s7 + 4'd3;
				jf_s8  <= jf;
				yp_s8  <= yoe_s7 + YOE_W'(jf);
				doy_s8 <= doy_s7;
				era_s8 <= era_s7;
				civ_s9.year  <= YEAR_W'(yp_s8) + YEAR_W'(era_s8) * YEAR_W'(400);
				civ_s9.month <= mon_s8;
				civ_s9.day   <= day_s8;
				civ_s9.leap  <= leap;
				civ_s9.yday  <= jf_s8 ? doy_s8 - YD_W'(305)
				                      : doy_s8 + YD_W'(60) + YD_W'(leap);
			end
		end

		assign civ[l] = civ_s9;
	end

endmodule

/* rtl/core/dnwd_week.sv */
// Week stage: ISO and US week numbers, year*100+week codes, missing-value zeroing.
// Depends on dnwd_pkg; the final add feeds the output buffer.
module dnwd_week
	import dnwd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  ctl_t  ctl_in,
	input  civ_t  civ_in [LANES],
	output logic  vld,
	output date_t date
);
	localparam int WPW = YD_W + WK7_MW;

	logic              vld_s1;
	logic              ok_s1;
	civ_t              dt_s1;
	logic [YEAR_W-1:0] ty_s1;
	logic [WEEK_W-1:0] iw_s1, uw_s1;
	logic [YW_W-1:0]   y100_s1, ty100_s1;

	// (yday - 1) / 7 + 1
	function automatic logic [WEEK_W-1:0] week_of(input logic [YD_W-1:0] yd);
		logic [WPW-1:0] prod;
		prod = WPW'(yd - YD_W'(1)) * WPW'(WK7_M);
		return prod[WK7_K +: WEEK_W] + WEEK_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= ctl_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s1    <= ctl_in.ok;
			dt_s1    <= civ_in[LANE_DATE];
			ty_s1    <= civ_in[LANE_THU].year;
			iw_s1    <= week_of(civ_in[LANE_THU].yday);
			uw_s1    <= week_of(civ_in[LANE_DATE].yday);
			y100_s1  <= YW_W'(civ_in[LANE_DATE].year) * YW_W'(100);
			ty100_s1 <= YW_W'(civ_in[LANE_THU].year) * YW_W'(100);
		end
	end

	always_comb begin
		date = '0;
		date.result_missing = 1'b1;
		if (ok_s1) begin
			date.result_missing = 1'b0;
			date.calendar_year  = dt_s1.year;
			date.calendar_month = dt_s1.month;
			date.calendar_day   = dt_s1.day;
			date.leap_flag      = dt_s1.leap;
			date.iso_week       = iw_s1;
			date.iso_year       = ty_s1;
			date.iso_year_week  = ty100_s1 + YW_W'(iw_s1);
			date.us_week        = uw_s1;
			date.us_year_week   = y100_s1 + YW_W'(uw_s1);
		end
	end

	assign vld = vld_s1;

endmodule

/* rtl/core/dnwd_skid.sv */
// Output register with a spare entry; ready toward the pipeline is registered.
// Depends on dnwd_pkg for the result type.
module dnwd_skid
	import dnwd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  fill_valid,
	input  date_t fill_data,
	output logic  fill_ready,
	output logic  drain_valid,
	input  logic  drain_ready,
	output date_t drain_data
);
	logic  main_vld_q;
	logic  spare_vld_q;
	date_t main_q;
	date_t spare_q;
	logic  push;
	logic  main_free;

	assign push      = fill_valid && !spare_vld_q;
	assign main_free = !main_vld_q || drain_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q  <= 1'b0;
			spare_vld_q <= 1'b0;
		end else if (main_free) begin
			main_vld_q  <= spare_vld_q || push;
			spare_vld_q <= 1'b0;
		end else if (push) begin
			spare_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (main_free) begin
			main_q <= spare_vld_q ? spare_q : fill_data;
		end else if (push) begin
			spare_q <= fill_data;
		end
	end

	assign fill_ready  = !spare_vld_q;
	assign drain_valid = main_vld_q;
	assign drain_data  = main_q;

endmodule
